// ----- hw/rtl/mlbpg_pkg.sv -----
// ----------------------------------------------------------------------------
// mlbpg_pkg
// Shared widths, constants and the command and status bundles that pass
// between the blink generator controller and its datapath.
// ----------------------------------------------------------------------------
package mlbpg_pkg;

   localparam int PERIOD_W = 16;
   localparam int DELAY_W  = 16;
   localparam int MODE_W   = 5;
   localparam int COUNT_W  = 17;
   localparam int HALF_W   = 16;
   localparam int LEVEL_W  = 4;
   localparam int IDXIN_W  = 2;

   // two times the largest blink count fits in this many bits
   localparam int DIVISOR_W = 5;

   localparam int DIV_STEPS  = PERIOD_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;

   localparam logic ACTION_TICK = 1'b0;
   localparam logic ACTION_SET  = 1'b1;

   localparam logic signed [MODE_W-1:0] MODE_OFF = 5'sd0;
   localparam logic signed [MODE_W-1:0] MODE_ON  = -5'sd1;

   typedef struct packed {
      logic load_item;
      logic walk_step;
      logic div_start;
      logic div_step;
      logic set_write;
      logic load_rsp;
   } mlbpg_cmd_type;

   typedef struct packed {
      logic is_tick;
      logic in_range;
      logic blink;
   } mlbpg_status_type;

endpackage

// ----- hw/rtl/mlbpg_datapath.sv -----
// ----------------------------------------------------------------------------
// mlbpg_datapath
// Per-LED state, the burst walk of one LED per step, the serial divider for
// the half-step and the result register.
// ----------------------------------------------------------------------------
module mlbpg_datapath
   import mlbpg_pkg::*;
#(
   parameter int LED_COUNT = 4,
   parameter int IDX_W     = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  mlbpg_cmd_type              cmd,
   input  logic [IDX_W-1:0]           walk_idx,
   output mlbpg_status_type           status,
   input  logic                       req_action,
   input  logic [IDXIN_W-1:0]         req_led_index,
   input  logic signed [MODE_W-1:0]   req_blink_mode,
   input  logic [DELAY_W-1:0]         req_start_delay,
   input  logic                       csr_write_enable,
   input  logic [PERIOD_W-1:0]        csr_write_data,
   output logic [LEVEL_W-1:0]         rsp_led_levels
);

   logic                      action_ff;
   logic [IDXIN_W-1:0]        index_ff;
   logic signed [MODE_W-1:0]  mode_ff;
   logic [DELAY_W-1:0]        delay_ff;

   logic [PERIOD_W-1:0]       period_ff, period_in;
   logic [LED_COUNT-1:0]      level_ff, level_in;
   logic [LED_COUNT-1:0]      blink_ff, blink_in;
   logic [COUNT_W-1:0]        count_ff [LED_COUNT];
   logic [COUNT_W-1:0]        count_in [LED_COUNT];
   logic [HALF_W-1:0]         phase_ff [LED_COUNT];
   logic [HALF_W-1:0]         phase_in [LED_COUNT];
   logic [HALF_W-1:0]         half_ff  [LED_COUNT];
   logic [HALF_W-1:0]         half_in  [LED_COUNT];
   logic [DELAY_W-1:0]        dly_ff   [LED_COUNT];
   logic [DELAY_W-1:0]        dly_in   [LED_COUNT];

   logic [PERIOD_W-1:0]       quot_ff, quot_in;
   logic [DIVISOR_W-1:0]      rem_ff, rem_in;
   logic [DIVISOR_W-1:0]      divisor_ff, divisor_in;
   logic [LEVEL_W-1:0]        levels_ff, levels_in;

   logic [COUNT_W-1:0]        cur_count;
   logic [HALF_W-1:0]         cur_phase;
   logic [HALF_W-1:0]         cur_half;
   logic [DELAY_W-1:0]        cur_delay;
   logic [COUNT_W-1:0]        restart_point;
   logic [COUNT_W-1:0]        phase_next;
   logic                      in_window;
   logic                      restart;
   logic [DIVISOR_W:0]        trial;
   logic                      trial_ge;
   logic [IDX_W-1:0]          set_idx;
   logic [HALF_W-1:0]         half_new;

   assign status.is_tick  = (action_ff == ACTION_TICK);
   assign status.in_range = ({30'd0, index_ff} < 32'(LED_COUNT));
   assign status.blink    = !mode_ff[MODE_W-1] && (mode_ff != MODE_OFF);

   assign set_idx  = IDX_W'(index_ff);
   assign half_new = (quot_ff == '0) ? HALF_W'(1) : quot_ff;

   assign cur_count = count_ff[walk_idx];
   assign cur_phase = phase_ff[walk_idx];
   assign cur_half  = half_ff[walk_idx];
   assign cur_delay = dly_ff[walk_idx];

   assign restart_point = {1'b0, period_ff} + {2'b00, period_ff[PERIOD_W-1:1]};
   assign in_window = (cur_count > {1'b0, cur_delay}) && (cur_count < {1'b0, period_ff});
   assign restart   = (cur_count >= restart_point);
   assign phase_next = {1'b0, cur_phase} + COUNT_W'(1);

   assign trial    = {rem_ff, quot_ff[PERIOD_W-1]};
   assign trial_ge = (trial >= {1'b0, divisor_ff});

   always_comb begin
      period_in  = period_ff;
      level_in   = level_ff;
      blink_in   = blink_ff;
      count_in   = count_ff;
      phase_in   = phase_ff;
      half_in    = half_ff;
      dly_in     = dly_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      levels_in  = levels_ff;

      if (csr_write_enable) begin
         period_in = csr_write_data;
      end

      if (cmd.walk_step && blink_ff[walk_idx]) begin
         if (restart && !in_window) begin
            count_in[walk_idx] = '0;
            phase_in[walk_idx] = '0;
         end else begin
            if (in_window) begin
               if (cur_phase == '0) begin
                  level_in[walk_idx] = !level_ff[walk_idx];
               end
            end else begin
               level_in[walk_idx] = 1'b0;
            end
            count_in[walk_idx] = cur_count + COUNT_W'(1);
            phase_in[walk_idx] = (phase_next == {1'b0, cur_half}) ? '0
                                                                  : phase_next[HALF_W-1:0];
         end
      end

      if (cmd.div_start) begin
         quot_in    = period_ff;
         rem_in     = '0;
         divisor_in = {mode_ff[DIVISOR_W-2:0], 1'b0};
      end else if (cmd.div_step) begin
         quot_in = {quot_ff[PERIOD_W-2:0], trial_ge};
         rem_in  = trial_ge ? DIVISOR_W'(trial - {1'b0, divisor_ff}) : trial[DIVISOR_W-1:0];
      end

      if (cmd.set_write) begin
         blink_in[set_idx] = status.blink;
         dly_in[set_idx]   = delay_ff;
         count_in[set_idx] = '0;
         phase_in[set_idx] = '0;
         if (mode_ff == MODE_OFF) begin
            level_in[set_idx] = 1'b0;
         end else if (mode_ff == MODE_ON) begin
            level_in[set_idx] = 1'b1;
         end
         if (status.blink) begin
            half_in[set_idx] = half_new;
         end
      end

      if (cmd.load_rsp) begin
         levels_in = LEVEL_W'(level_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
         level_ff  <= '0;
         blink_ff  <= '0;
      end else begin
         period_ff <= period_in;
         level_ff  <= level_in;
         blink_ff  <= blink_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         action_ff <= req_action;
         index_ff  <= req_led_index;
         mode_ff   <= req_blink_mode;
         delay_ff  <= req_start_delay;
      end
      count_ff   <= count_in;
      phase_ff   <= phase_in;
      half_ff    <= half_in;
      dly_ff     <= dly_in;
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      levels_ff  <= levels_in;
   end

   assign rsp_led_levels = levels_ff;

endmodule

// ----- hw/rtl/mlbpg_controller.sv -----
// ----------------------------------------------------------------------------
// mlbpg_controller
// Sequencer: takes one item, walks the LEDs for a tick or runs the divider
// for a set to blinking, then hands the levels to the result register.
// ----------------------------------------------------------------------------
module mlbpg_controller
   import mlbpg_pkg::*;
#(
   parameter int LED_COUNT = 4,
   parameter int IDX_W     = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  mlbpg_status_type  status,
   output mlbpg_cmd_type     cmd,
   output logic [IDX_W-1:0]  walk_idx
);

   typedef enum logic [2:0] {
      IDLE,
      DECODE,
      WALK,
      DIVIDE,
      WRITE,
      FINISH
   } state_type;

   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     walk_ff, walk_in;
   logic [DIV_CNT_W-1:0] div_ff, div_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign walk_idx  = walk_ff;

   always_comb begin
      state_in     = state_ff;
      walk_in      = walk_ff;
      div_in       = div_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;

      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = DECODE;
            end
         end
         DECODE: begin
            walk_in = '0;
            div_in  = '0;
            if (status.is_tick) begin
               state_in = WALK;
            end else if (status.in_range && status.blink) begin
               cmd.div_start = 1'b1;
               state_in      = DIVIDE;
            end else begin
               cmd.set_write = status.in_range;
               state_in      = FINISH;
            end
         end
         WALK: begin
            cmd.walk_step = 1'b1;
            if (walk_ff == IDX_W'(LED_COUNT - 1)) begin
               state_in = FINISH;
            end else begin
               walk_in = walk_ff + IDX_W'(1);
            end
         end
         DIVIDE: begin
            cmd.div_step = 1'b1;
            div_in       = div_ff + DIV_CNT_W'(1);
            if (div_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = WRITE;
            end
         end
         WRITE: begin
            cmd.set_write = 1'b1;
            state_in      = FINISH;
         end
         FINISH: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         walk_ff      <= '0;
         div_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         walk_ff      <= walk_in;
         div_ff       <= div_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- hw/rtl/multi_led_blink_pattern_generator_unit.sv -----
// ----------------------------------------------------------------------------
// multi_led_blink_pattern_generator_unit
// Bank of LEDs, each off, always on, or blinking a set number of times per
// burst window.
//
// Input channel req_*: one transfer is either a tick (req_action low) or a
// set of one LED's mode and start delay (req_action high). Every transfer
// yields exactly one transfer on rsp_* carrying all LED levels.
// csr_write_data sets the tick period; write it only while the block idles.
//
// Work per item, from the accepted item to the result register:
//   tick:                 one LED per cycle through the walk
//   set to blinking:      the 16-step serial half-step divider, then the write
//   set off, on or other: decode writes the LED directly if its index is in range
// A new item is taken the cycle after the result is loaded.
// The result register holds while rsp_stall is high; the next item is still
// taken and worked, and waits for the register before it is delivered.
// Reset (synchronous) clears all levels and modes and sets the period to 1000.
// ----------------------------------------------------------------------------
module multi_led_blink_pattern_generator_unit
   import mlbpg_pkg::*;
#(
   parameter int LED_COUNT = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_action,
   input  logic [IDXIN_W-1:0]        req_led_index,
   input  logic signed [MODE_W-1:0]  req_blink_mode,
   input  logic [DELAY_W-1:0]        req_start_delay,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [LEVEL_W-1:0]        rsp_led_levels,
   input  logic                      csr_write_enable,
   input  logic [PERIOD_W-1:0]       csr_write_data
);

   localparam int IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

   mlbpg_cmd_type    cmd;
   mlbpg_status_type status;
   logic [IDX_W-1:0] walk_idx;

   mlbpg_controller #(
      .LED_COUNT (LED_COUNT),
      .IDX_W     (IDX_W)
   ) u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd),
      .walk_idx  (walk_idx)
   );

   mlbpg_datapath #(
      .LED_COUNT (LED_COUNT),
      .IDX_W     (IDX_W)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .walk_idx         (walk_idx),
      .status           (status),
      .req_action       (req_action),
      .req_led_index    (req_led_index),
      .req_blink_mode   (req_blink_mode),
      .req_start_delay  (req_start_delay),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_led_levels   (rsp_led_levels)
   );

endmodule

// ----- hw/rtl/mlbpg_checker.sv -----
// ----------------------------------------------------------------------------
// mlbpg_checker
// Port-level checks of the blink generator, bound to the top level.
// ----------------------------------------------------------------------------
module mlbpg_checker
   import mlbpg_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic                      req_action,
   input logic [IDXIN_W-1:0]        req_led_index,
   input logic signed [MODE_W-1:0]  req_blink_mode,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic [LEVEL_W-1:0]        rsp_led_levels
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_led_levels))
      else $error("stalled result changed");

   // one item at a time: busy right after a transfer
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken while an item is in work");

   // forcing LED 0 on shows in the result after the decode and finish states
   a_force_on: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_action == ACTION_SET) && (req_led_index == '0)
      && (req_blink_mode == MODE_ON) && !rsp_valid
      |-> ##3 rsp_valid && rsp_led_levels[0])
      else $error("LED 0 not on after a set to always on");

   // drop any result on reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind multi_led_blink_pattern_generator_unit mlbpg_checker u_checker (.*);
